[hdl/tmf_pkg.sv]
// ----------------------------------------------------------------------------
// tmf_pkg - shared types and constants
// Widths, sequencer states and divider handshake structs for the trimmed
// mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

    localparam int MAX_WINDOW = 16;

    localparam int DATA_W = 16;
    localparam int CFG_W  = 5;
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int TAKE_W = $clog2(MAX_WINDOW / 2 + 1);
    localparam int SUM_W  = DATA_W + TAKE_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [TAKE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hdl/tmf_store.sv]
// ----------------------------------------------------------------------------
// tmf_store - sample window memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmf_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tmf_pkg::ADDR_W-1:0] i_waddr,
    input  logic [tmf_pkg::DATA_W-1:0] i_wdata,
    input  logic [tmf_pkg::ADDR_W-1:0] i_raddr,
    output logic [tmf_pkg::DATA_W-1:0] o_rdata
);

    logic [tmf_pkg::DATA_W-1:0] r_mem [tmf_pkg::MAX_WINDOW];
    logic [tmf_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tmf_div.sv]
// ----------------------------------------------------------------------------
// tmf_div - serial restoring divider
// One quotient bit per cycle; quotient holds after done until next start.
// ----------------------------------------------------------------------------
module tmf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmf_pkg::t_div_req i_req,
    output tmf_pkg::t_div_rsp o_rsp
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [tmf_pkg::DCNT_W-1:0]  r_cnt, n_cnt;
    logic [tmf_pkg::TAKE_W-1:0]  r_rem, n_rem;
    logic [tmf_pkg::TAKE_W-1:0]  r_dvs, n_dvs;
    logic [tmf_pkg::SUM_W-1:0]   r_quo, n_quo;
    logic [tmf_pkg::TAKE_W:0]    trial;
    logic                        q_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[tmf_pkg::SUM_W-1]};
        q_bit  = (trial >= {1'b0, r_dvs});
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            if (q_bit) begin
                n_rem = tmf_pkg::TAKE_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[tmf_pkg::TAKE_W-1:0];
            end
            n_quo = {r_quo[tmf_pkg::SUM_W-2:0], q_bit};
            n_cnt = r_cnt + tmf_pkg::DCNT_W'(1);
            if (r_cnt == tmf_pkg::DCNT_W'(tmf_pkg::SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[hdl/trimmed_mean_filter_u16.sv]
// ----------------------------------------------------------------------------
// trimmed_mean_filter_u16 - interquartile trimmed mean of a sample window
// Collects window_length samples and returns the mean of the middle half.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one 16-bit sample per item. Output stream m_axis_*:
//   one 16-bit trimmed mean per completed window. i_cfg_wr_en/i_cfg_wr_data
//   set window_length (values below 2 act as 2, above 16 as 16) and drop any
//   partial window; write it only while the block is idle.
//   Each sample is insertion-sorted into the window memory as it arrives:
//   each stored entry above it is read, then compared and, if larger,
//   written one place up; s_axis_tready stays low from acceptance until the
//   sample is written in its place.
//   The sample that completes a window then sums the middle entries, each
//   read and then accumulated, runs the serial divider and loads the output
//   register, with s_axis_tready low throughout; the registered memory read
//   port and the one-bit-per-cycle divider set how long this takes.
//   The output register holds a result until taken; the block goes on with
//   the next window and waits only if a second result is ready before then.
//   Reset empties the window, sets window_length to 16 and clears m_axis_tvalid.
// ----------------------------------------------------------------------------
module trimmed_mean_filter_u16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,   // window_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [15:0] trimmed_mean
);

    tmf_pkg::t_state r_state, n_state;

    logic [tmf_pkg::CFG_W-1:0]  r_cfg_len;
    logic [tmf_pkg::LEN_W-1:0]  r_fill, n_fill;
    logic [tmf_pkg::DATA_W-1:0] r_key, n_key;
    logic [tmf_pkg::ADDR_W-1:0] r_k, n_k;
    logic [tmf_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic [tmf_pkg::TAKE_W-1:0] r_left, n_left;
    logic [tmf_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic                       r_out_valid, n_out_valid;
    logic [tmf_pkg::DATA_W-1:0] r_out_data, n_out_data;

    logic [tmf_pkg::LEN_W-1:0]  eff_len;
    logic [tmf_pkg::LEN_W-1:0]  fill_inc;
    logic [tmf_pkg::ADDR_W-1:0] start_idx;
    logic [tmf_pkg::TAKE_W-1:0] take;
    logic                       ins_done;

    logic                       mem_we;
    logic [tmf_pkg::ADDR_W-1:0] mem_waddr;
    logic [tmf_pkg::DATA_W-1:0] mem_wdata;
    logic [tmf_pkg::ADDR_W-1:0] mem_raddr;
    logic [tmf_pkg::DATA_W-1:0] mem_rdata;

    tmf_pkg::t_div_req div_req;
    tmf_pkg::t_div_rsp div_rsp;

    tmf_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_cfg_len < tmf_pkg::CFG_W'(2)) begin
            eff_len = tmf_pkg::LEN_W'(2);
        end else if (int'(r_cfg_len) > tmf_pkg::MAX_WINDOW) begin
            eff_len = tmf_pkg::LEN_W'(tmf_pkg::MAX_WINDOW);
        end else begin
            eff_len = tmf_pkg::LEN_W'(r_cfg_len);
        end
    end

    assign fill_inc  = r_fill + tmf_pkg::LEN_W'(1);
    assign start_idx = tmf_pkg::ADDR_W'(eff_len >> 2);
    assign take      = tmf_pkg::TAKE_W'(eff_len >> 1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_key       = r_key;
        n_k         = r_k;
        n_idx       = r_idx;
        n_left      = r_left;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ins_done    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = r_key;
        mem_raddr   = r_idx;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum;
        div_req.divisor  = take;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tmf_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key   = s_axis_tdata;
                    n_k     = tmf_pkg::ADDR_W'(r_fill);
                    n_state = tmf_pkg::S_INS_RD;
                end
            end
            tmf_pkg::S_INS_RD: begin
                mem_raddr = r_k - tmf_pkg::ADDR_W'(1);
                if (r_k == '0) begin
                    mem_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    n_state = tmf_pkg::S_INS_CMP;
                end
            end
            tmf_pkg::S_INS_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata > r_key) begin
                    mem_wdata = mem_rdata;
                    n_k       = r_k - tmf_pkg::ADDR_W'(1);
                    n_state   = tmf_pkg::S_INS_RD;
                end else begin
                    ins_done = 1'b1;
                end
            end
            tmf_pkg::S_SUM_RD: begin
                n_state = tmf_pkg::S_SUM_ACC;
            end
            tmf_pkg::S_SUM_ACC: begin
                n_sum  = r_sum + tmf_pkg::SUM_W'(mem_rdata);
                n_idx  = r_idx + tmf_pkg::ADDR_W'(1);
                n_left = r_left - tmf_pkg::TAKE_W'(1);
                if (r_left == tmf_pkg::TAKE_W'(1)) begin
                    n_state = tmf_pkg::S_DIV_START;
                end else begin
                    n_state = tmf_pkg::S_SUM_RD;
                end
            end
            tmf_pkg::S_DIV_START: begin
                div_req.start = 1'b1;
                n_state       = tmf_pkg::S_DIV_WAIT;
            end
            tmf_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = tmf_pkg::S_OUT;
                end
            end
            tmf_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = div_rsp.quotient[tmf_pkg::DATA_W-1:0];
                    n_state     = tmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tmf_pkg::S_IDLE;
            end
        endcase

        if (ins_done) begin
            if (fill_inc == eff_len) begin
                n_fill  = '0;
                n_idx   = start_idx;
                n_left  = take;
                n_sum   = '0;
                n_state = tmf_pkg::S_SUM_RD;
            end else begin
                n_fill  = fill_inc;
                n_state = tmf_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmf_pkg::S_IDLE;
            r_cfg_len   <= tmf_pkg::CFG_W'(16);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cfg_len <= i_cfg_wr_data;
                r_fill    <= '0;
            end else begin
                r_fill    <= n_fill;
            end
        end
        r_key      <= n_key;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == tmf_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[hdl/tmf_checker.sv]
// ----------------------------------------------------------------------------
// tmf_checker - port-level checks for the trimmed mean filter
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module tmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // accepting an item takes the block out of idle, so ready drops
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an accepted item");

    // a new result is loaded only while busy
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind trimmed_mean_filter_u16 tmf_checker u_tmf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
